### rtl/srr_pkg.sv
// ----------------------------------------------------------------------------
// srr_pkg: shared types and constants for the stepper reversal ramp
// Holds the ramp phase codes, operation codes, register indexes, the state
// record and the reset values used by the datapath and the top level.
// ----------------------------------------------------------------------------
package srr_pkg;

    localparam int RATE_W = 16;
    localparam int TIME_W = 32;
    localparam int PH_W   = 2;
    localparam int OP_W   = 2;
    localparam int CFG_W  = 2;

    // Ramp phase codes
    localparam logic [PH_W-1:0] PH_STEADY = 2'd0;
    localparam logic [PH_W-1:0] PH_DECEL  = 2'd1;
    localparam logic [PH_W-1:0] PH_ACCEL  = 2'd2;

    // Operation codes
    localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
    localparam logic [OP_W-1:0] OP_POWER = 2'd1;
    localparam logic [OP_W-1:0] OP_DIR   = 2'd2;

    // Register indexes
    localparam logic [CFG_W-1:0] CFG_TARGET   = 2'd0;
    localparam logic [CFG_W-1:0] CFG_STEP     = 2'd1;
    localparam logic [CFG_W-1:0] CFG_INTERVAL = 2'd2;

    // Register reset values
    localparam logic [RATE_W-1:0] TARGET_RST   = 16'd1000;
    localparam logic [RATE_W-1:0] STEP_RST     = 16'd100;
    localparam logic [RATE_W-1:0] INTERVAL_RST = 16'd10;

    // Default rate limits
    localparam logic [RATE_W-1:0] MIN_RATE_HZ_DEF = 16'd1;
    localparam logic [RATE_W-1:0] MAX_RATE_HZ_DEF = 16'd65535;

    // Drive state
    typedef struct packed {
        logic              powered;
        logic [PH_W-1:0]   phase;
        logic [RATE_W-1:0] rate;
        logic              motor_dir;
        logic              pending_dir;
        logic [TIME_W-1:0] last_ramp;
    } t_state;

    // Configuration as seen by the datapath
    typedef struct packed {
        logic [RATE_W-1:0] target;
        logic [RATE_W-1:0] step;
        logic [RATE_W-1:0] interval;
    } t_cfg;

    // One input request, unpacked
    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [TIME_W-1:0] now;
        logic              cmd;
        logic              left_rose;
        logic              right_rose;
        logic              left_det;
        logic              right_det;
    } t_item;

endpackage

### rtl/stepper_reversal_ramp.sv
// ----------------------------------------------------------------------------
// stepper_reversal_ramp: end-stop shuttle drive with reversal ramp
// Top level: configuration registers, drive state, next-state logic and a
// two-entry result queue on the output stream.
// ----------------------------------------------------------------------------
// Each request accepted is applied to the drive state, unless a configuration
// write is taken in the same cycle; its result (rate, direction, enable, ramp
// phase) is registered into the result queue, offered after earlier results.
// One request per clock is sustained while the output takes results; the
// next-state logic is combinational (one 32-bit elapsed-time compare and one
// 17-bit rate add or 16-bit subtract). A two-entry result queue stalls the
// input only when both entries are full. Configuration writes are taken at
// any time and should be made while the stream is idle.
module stepper_reversal_ramp #(
    parameter logic [srr_pkg::RATE_W-1:0] MIN_RATE_HZ = srr_pkg::MIN_RATE_HZ_DEF,
    parameter logic [srr_pkg::RATE_W-1:0] MAX_RATE_HZ = srr_pkg::MAX_RATE_HZ_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Input stream
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    // tdata: now_ms[31:0], command_value[32], left_rose[33], right_rose[34],
    //        left_detected[35], right_detected[36], zero[39:37]
    input  logic [39:0]                 i_s_tdata,
    // tuser: operation[1:0]
    input  logic [srr_pkg::OP_W-1:0]    i_s_tuser,
    // Output stream
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    // tdata: speed_hz[15:0], direction_forward[16], driver_enable[17],
    //        ramp_phase[19:18], zero[23:20]
    output logic [23:0]                 o_m_tdata,
    // Configuration write
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [srr_pkg::CFG_W-1:0]   i_cfg_index,
    input  logic [srr_pkg::RATE_W-1:0]  i_cfg_data
);
    import srr_pkg::*;

    localparam int RES_W = RATE_W + 2 + PH_W;

    function automatic logic [RATE_W-1:0] clamp_rate(logic [RATE_W-1:0] v);
        logic [RATE_W-1:0] r;
        r = v;
        if (r < MIN_RATE_HZ) r = MIN_RATE_HZ;
        if (r > MAX_RATE_HZ) r = MAX_RATE_HZ;
        return r;
    endfunction

    t_cfg              r_cfg;
    t_state            r_state;
    t_state            n_state;
    t_item             w_item;
    logic [RATE_W-1:0] w_target;
    logic              w_in_acc;
    logic              w_out_acc;
    logic              w_cfg_acc;
    logic [RES_W-1:0]  w_res;
    logic [RES_W-1:0]  r_q0;
    logic [RES_W-1:0]  r_q1;
    logic [1:0]        r_cnt;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_acc   = i_cfg_valid;
    assign o_s_tready  = (r_cnt != 2'd2);
    assign w_in_acc    = i_s_tvalid && o_s_tready;
    assign o_m_tvalid  = (r_cnt != 2'd0);
    assign w_out_acc   = o_m_tvalid && i_m_tready;
    assign w_target    = clamp_rate(i_cfg_data);

    // Unpack the request
    always_comb begin
        w_item.op         = i_s_tuser;
        w_item.now        = i_s_tdata[31:0];
        w_item.cmd        = i_s_tdata[32];
        w_item.left_rose  = i_s_tdata[33];
        w_item.right_rose = i_s_tdata[34];
        w_item.left_det   = i_s_tdata[35];
        w_item.right_det  = i_s_tdata[36];
    end

    srr_next u_next (
        .i_state (r_state),
        .i_cfg   (r_cfg),
        .i_item  (w_item),
        .o_state (n_state)
    );

    // Result of the accepted request
    assign w_res = {n_state.phase, n_state.powered, n_state.motor_dir, n_state.rate};

    // Hold configuration and drive state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.target      <= clamp_rate(TARGET_RST);
            r_cfg.step        <= STEP_RST;
            r_cfg.interval    <= INTERVAL_RST;
            r_state.powered   <= 1'b0;
            r_state.phase     <= PH_STEADY;
            r_state.rate      <= '0;
            r_state.motor_dir <= 1'b1;
            r_state.pending_dir <= 1'b0;
            r_state.last_ramp <= '0;
        end else if (w_cfg_acc) begin
            case (i_cfg_index)
                CFG_TARGET: begin
                    r_cfg.target <= w_target;
                    if (r_state.powered && r_state.phase == PH_STEADY) begin
                        r_state.rate <= w_target;
                    end
                end
                CFG_STEP:     r_cfg.step     <= i_cfg_data;
                CFG_INTERVAL: r_cfg.interval <= i_cfg_data;
                default: begin
                end
            endcase
        end else if (w_in_acc) begin
            r_state <= n_state;
        end
    end

    // Advance the result queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            case ({w_in_acc, w_out_acc})
                2'b10: r_cnt <= r_cnt + 2'd1;
                2'b01: r_cnt <= r_cnt - 2'd1;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case ({w_in_acc, w_out_acc})
            2'b10: begin
                if (r_cnt == 2'd0) r_q0 <= w_res;
                else               r_q1 <= w_res;
            end
            2'b01: r_q0 <= r_q1;
            2'b11: begin
                if (r_cnt == 2'd1) begin
                    r_q0 <= w_res;
                end else begin
                    r_q0 <= r_q1;
                    r_q1 <= w_res;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_m_tdata = {{(24-RES_W){1'b0}}, r_q0};

endmodule

### rtl/srr_next.sv
// ----------------------------------------------------------------------------
// srr_next: next-state logic of the stepper reversal ramp
// Applies one request (tick, power command or direction request) to the
// present drive state and returns the state after it.
// ----------------------------------------------------------------------------
module srr_next (
    input  srr_pkg::t_state i_state,
    input  srr_pkg::t_cfg   i_cfg,
    input  srr_pkg::t_item  i_item,
    output srr_pkg::t_state o_state
);
    import srr_pkg::*;

    // Take a direction request: flip at once when stopped, else start ramp-down
    function automatic t_state ask_dir(t_state s, logic dir, logic [TIME_W-1:0] now);
        t_state r;
        r = s;
        if (dir != s.motor_dir && !(s.phase != PH_STEADY && dir == s.pending_dir)) begin
            r.pending_dir = dir;
            if (!s.powered || s.rate == '0) begin
                r.motor_dir = dir;
                r.phase     = PH_STEADY;
            end else begin
                r.phase     = PH_DECEL;
                r.last_ramp = now;
            end
        end
        return r;
    endfunction

    // Make one ramp step when the interval has gone by
    function automatic t_state ramp(t_state s, t_cfg c, logic [TIME_W-1:0] now);
        t_state            r;
        logic [RATE_W-1:0] step;
        logic [TIME_W-1:0] elapsed;
        logic [RATE_W:0]   sum;
        r       = s;
        step    = (c.step == '0) ? RATE_W'(1) : c.step;
        elapsed = now - s.last_ramp;
        sum     = {1'b0, s.rate} + {1'b0, step};
        if (s.phase != PH_STEADY && elapsed >= {{(TIME_W-RATE_W){1'b0}}, c.interval}) begin
            r.last_ramp = now;
            if (s.phase == PH_DECEL) begin
                if (s.rate <= step) begin
                    r.motor_dir = s.pending_dir;
                    r.rate      = (c.target < step) ? c.target : step;
                    r.phase     = (r.rate >= c.target) ? PH_STEADY : PH_ACCEL;
                end else begin
                    r.rate = s.rate - step;
                end
            end else begin
                if (sum >= {1'b0, c.target}) begin
                    r.rate  = c.target;
                    r.phase = PH_STEADY;
                end else begin
                    r.rate = sum[RATE_W-1:0];
                end
            end
        end
        return r;
    endfunction

    // Dispatch on the operation
    always_comb begin
        t_state s;
        s = i_state;
        case (i_item.op)
            OP_TICK: begin
                if (s.powered) begin
                    if (i_item.left_rose || i_item.right_rose) begin
                        s = ask_dir(s, !i_item.left_rose, i_item.now);
                    end
                    s = ramp(s, i_cfg, i_item.now);
                end
            end
            OP_POWER: begin
                if (i_item.cmd != s.powered) begin
                    if (i_item.cmd) begin
                        s.powered = 1'b1;
                        if (i_item.left_det || i_item.right_det) begin
                            s = ask_dir(s, !i_item.left_det, i_item.now);
                        end
                        s.rate = i_cfg.target;
                    end else begin
                        s.powered = 1'b0;
                        s.phase   = PH_STEADY;
                        s.rate    = '0;
                    end
                end
            end
            OP_DIR: begin
                s = ask_dir(s, i_item.cmd, i_item.now);
            end
            default: begin
            end
        endcase
        o_state = s;
    end

endmodule

### rtl/srr_checker.sv
// ----------------------------------------------------------------------------
// srr_checker: port-level checks for the stepper reversal ramp
// Watches the output stream of the top level and is bound to it below.
// ----------------------------------------------------------------------------
module srr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [23:0] o_m_tdata
);
    import srr_pkg::*;

    // A stalled result stays offered
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("result dropped while stalled");

    // A stalled result keeps its value
    a_data_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> $stable(o_m_tdata))
        else $error("result changed while stalled");

    // A disabled driver reports zero rate and no ramp
    a_off_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tdata[17] |->
            o_m_tdata[15:0] == 16'd0 && o_m_tdata[19:18] == PH_STEADY)
        else $error("disabled driver reports motion");

    // Ramp phase is never the unused code and the padding bits are zero
    a_phase_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[19:18] != 2'd3 && o_m_tdata[23:20] == 4'd0)
        else $error("bad phase or padding in result");

endmodule

bind stepper_reversal_ramp srr_checker u_srr_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
